/* rtl/lru_pr_pkg.sv */
// Shared constants and types for the LRU page replacement block.
// No dependencies; every other file imports this package.
package lru_pr_pkg;

   // Sizes of the recency list and of the item fields
   localparam int MAX_FRAMES = 16;
   localparam int IDX_W      = $clog2(MAX_FRAMES);
   localparam int CNT_W      = $clog2(MAX_FRAMES + 1);
   localparam int PAGE_W     = 10;
   localparam int CFG_W      = 5;
   localparam int FRAMES_RESET = 16;

   // Controller states
   typedef enum logic [0:0] {
      ST_IDLE,
      ST_EXEC
   } lru_state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic capture;   // latch the incoming page number
      logic commit;    // update the list and load the result register
   } lru_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic out_busy;  // result register holds an item not yet taken
   } lru_status_type;

endpackage

/* rtl/lru_pr_if.sv */
// Channel interfaces for the LRU page replacement block.
// Depends on lru_pr_pkg for field widths.
interface lru_req_if;
   import lru_pr_pkg::*;
   logic              valid;
   logic              ready;
   logic [PAGE_W-1:0] page_number;
   modport source (output valid, output page_number, input ready);
   modport sink   (input valid, input page_number, output ready);
endinterface

interface lru_rsp_if;
   import lru_pr_pkg::*;
   logic              valid;
   logic              ready;
   logic              hit;
   logic              evict_valid;
   logic [PAGE_W-1:0] evicted_page;
   logic [CNT_W-1:0]  occupancy;
   modport source (output valid, output hit, output evict_valid, output evicted_page,
                   output occupancy, input ready);
   modport sink   (input valid, input hit, input evict_valid, input evicted_page,
                   input occupancy, output ready);
endinterface

interface lru_csr_if;
   import lru_pr_pkg::*;
   logic             valid;
   logic             ready;
   logic [CFG_W-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

/* rtl/lru_pr_ctrl.sv */
// Controller state machine: accepts an item, then commits it once the
// result register is free. Depends on lru_pr_pkg.
module lru_pr_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   output lru_pr_pkg::lru_cmd_type    cmd,
   input  lru_pr_pkg::lru_status_type status
);
   import lru_pr_pkg::*;

   lru_state_type state_ff, state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (!status.out_busy) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready   = 1'b0;
      cmd.capture = 1'b0;
      cmd.commit  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         ST_EXEC: begin
            cmd.commit = !status.out_busy;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

endmodule

/* rtl/lru_pr_dp.sv */
// Datapath: recency list with parallel compare and shift, occupancy count,
// frame limit register and result register. Depends on lru_pr_pkg, lru_pr_if.
module lru_pr_dp (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [lru_pr_pkg::PAGE_W-1:0]    page_number,
   input  lru_pr_pkg::lru_cmd_type          cmd,
   output lru_pr_pkg::lru_status_type       status,
   lru_rsp_if.source                        rsp,
   lru_csr_if.sink                          csr
);
   import lru_pr_pkg::*;

   logic [PAGE_W-1:0] list_ff [MAX_FRAMES];
   logic [PAGE_W-1:0] list_in [MAX_FRAMES];
   logic [CNT_W-1:0]  filled_ff, filled_in;
   logic [CFG_W-1:0]  limit_ff;
   logic [PAGE_W-1:0] page_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              hit_ff;
   logic              evict_ff;
   logic [PAGE_W-1:0] victim_ff;
   logic [CNT_W-1:0]  occ_ff;

   logic [MAX_FRAMES-1:0] match;
   logic                  hit;
   logic [IDX_W-1:0]      pos;
   logic [CNT_W-1:0]      lim;
   logic                  evict;
   logic [CNT_W-1:0]      last;
   logic [PAGE_W-1:0]     victim;
   logic [CNT_W-1:0]      base;
   logic [IDX_W-1:0]      upto;

   assign csr.ready       = 1'b1;
   assign status.out_busy = rsp_valid_ff && !rsp.ready;

   // associative lookup over valid entries, lowest position wins
   always_comb begin
      pos = '0;
      for (int i = 0; i < MAX_FRAMES; i++) begin
         match[i] = (list_ff[i] == page_ff) && (CNT_W'(i) < filled_ff);
      end
      for (int i = MAX_FRAMES - 1; i >= 0; i--) begin
         if (match[i]) pos = IDX_W'(i);
      end
      hit = |match;
   end

   // effective frame limit: zero acts as one, clamp at list depth
   always_comb begin
      if (limit_ff == '0)                     lim = CNT_W'(1);
      else if (int'(limit_ff) > MAX_FRAMES)   lim = CNT_W'(MAX_FRAMES);
      else                                    lim = CNT_W'(limit_ff);
   end

   // eviction of the tail entry on a miss when full
   assign evict  = !hit && (filled_ff >= lim);
   assign last   = filled_ff - CNT_W'(1);
   assign victim = list_ff[last[IDX_W-1:0]];
   assign base   = evict ? last : filled_ff;

   // shift span and next list contents
   always_comb begin
      if (hit)                              upto = pos;
      else if (int'(base) >= MAX_FRAMES)    upto = IDX_W'(MAX_FRAMES - 1);
      else                                  upto = base[IDX_W-1:0];
      list_in[0] = page_ff;
      for (int i = 1; i < MAX_FRAMES; i++) begin
         if (IDX_W'(i) <= upto) list_in[i] = list_ff[i-1];
         else                   list_in[i] = list_ff[i];
      end
      filled_in = hit ? filled_ff : base + CNT_W'(1);
   end

   // result valid: set on commit, cleared when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit)     rsp_valid_in = 1'b1;
      else if (rsp.ready) rsp_valid_in = 1'b0;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         filled_ff    <= '0;
         limit_ff     <= CFG_W'(FRAMES_RESET);
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (cmd.commit) filled_ff <= filled_in;
         if (csr.valid)  limit_ff  <= csr.data;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.capture) page_ff <= page_number;
      if (cmd.commit) begin
         for (int i = 0; i < MAX_FRAMES; i++) list_ff[i] <= list_in[i];
         hit_ff    <= hit;
         evict_ff  <= evict;
         victim_ff <= evict ? victim : '0;
         occ_ff    <= filled_in;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.hit          = hit_ff;
   assign rsp.evict_valid  = evict_ff;
   assign rsp.evicted_page = victim_ff;
   assign rsp.occupancy    = occ_ff;

endmodule

/* rtl/lru_page_replacement_top.sv */
// LRU page replacement, top level. An item is accepted and its page number registered, then
// the controller commits it: list update, result load. No new item is taken before that;
// a waiting result stalls the update step and the input stays not ready until it is taken.
// Reset: synchronous, active high; empties the list, sets the frame limit to 16.
// Depends on lru_pr_pkg, lru_pr_if, lru_pr_ctrl, lru_pr_dp.
module lru_page_replacement_top (
   input  logic        clock,
   input  logic        reset,
   lru_req_if.sink     req_ch,
   lru_rsp_if.source   rsp_ch,
   lru_csr_if.sink     csr_ch
);
   import lru_pr_pkg::*;

   lru_cmd_type    cmd;
   lru_status_type status;

   // sequencing
   lru_pr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .cmd       (cmd),
      .status    (status)
   );

   // list, counters and result register
   lru_pr_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .page_number (req_ch.page_number),
      .cmd         (cmd),
      .status      (status),
      .rsp         (rsp_ch),
      .csr         (csr_ch)
   );

endmodule
